/* design/page_translate_lru_replace_assert.svh */
// Assertion macros for the page translation block.
// Standalone header; included by modules that carry concurrent checks.
`ifndef PAGE_TRANSLATE_LRU_REPLACE_ASSERT_SVH
`define PAGE_TRANSLATE_LRU_REPLACE_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define PTLR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ptlr assertion failed");
// Check that a condition holds in the cycle after its trigger.
`define PTLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptlr assertion failed");
`else
`define PTLR_ASSERT(lbl, prop)
`define PTLR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/ptlr_pkg.sv */
// Shared constants and helpers for the page translation block.
// No dependencies; imported by page_translate_lru_replace.
package ptlr_pkg;

    localparam int OFFSET_BITS     = 7;
    localparam int VIRTUAL_PAGES   = 32;
    localparam int PHYSICAL_FRAMES = 8;

    localparam int ADDR_W  = 12;
    localparam int PA_W    = 10;
    localparam int CNT_W   = 32;
    localparam int FC_W    = 4;
    localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);

    localparam logic [FC_W-1:0] FC_RESET = FC_W'(8);
    localparam logic [FC_W-1:0] FC_MIN   = FC_W'(2);

    localparam int IN_TDATA_W  = ((ADDR_W + 7) / 8) * 8;
    localparam int OUT_BITS    = PA_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Page number: upper address bits, wrapped to the table size
    function automatic logic [PAGE_W-1:0] page_of(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] pn;
        pn = addr >> OFFSET_BITS;
        return PAGE_W'(pn % ADDR_W'(VIRTUAL_PAGES));
    endfunction

    function automatic logic [OFFSET_BITS-1:0] offset_of(input logic [ADDR_W-1:0] addr);
        return addr[OFFSET_BITS-1:0];
    endfunction

endpackage

/* design/page_translate_lru_replace.sv */
// Demand-paging address translation with least recently used replacement.
// A hit passes the lookup and write states; a miss scans the active frames from frame 1
// up, takes the lowest free frame, or evicts when none is free; the frame scan checks
// one frame a cycle. One word is in flight at a time and the next is accepted in the
// cycle after the result is registered; the write state waits while the output stalls.
// Synchronous active-low reset empties the page table, frees frames 1 and up, zeroes
// the access clock and fault count, sets 8 frames.
`include "page_translate_lru_replace_assert.svh"

module page_translate_lru_replace #(
    parameter int PHYSICAL_FRAMES = ptlr_pkg::PHYSICAL_FRAMES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [ptlr_pkg::FC_W-1:0]            i_cfg_wr_data,   // frame_count
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [ptlr_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // [11:0] logical_address
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [ptlr_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,  // [9:0] physical_address,
                                                                  // [41:10] fault_total
    output logic                                 o_m_axis_tuser   // [0] page_fault
);
    import ptlr_pkg::*;

    localparam int FW = $clog2(PHYSICAL_FRAMES);
    localparam int CW = $clog2(PHYSICAL_FRAMES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_WRITE
    } t_state;

    // Storage
    logic [FW-1:0]     m_page_frame [VIRTUAL_PAGES];
    logic [CNT_W-1:0]  m_last_use   [PHYSICAL_FRAMES];
    logic [PAGE_W-1:0] m_owner      [PHYSICAL_FRAMES];

    logic [FW-1:0]     r_pf_rd;
    logic [CNT_W-1:0]  r_lu_rd;
    logic [PAGE_W-1:0] r_own_rd;

    logic [VIRTUAL_PAGES-1:0]   r_valid;
    logic [VIRTUAL_PAGES-1:0]   n_valid;
    logic [PHYSICAL_FRAMES-1:0] r_free;
    logic [FC_W-1:0]            r_frame_count;

    t_state               r_state;
    logic [PAGE_W-1:0]    r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [CNT_W-1:0]     r_clock;
    logic [CNT_W-1:0]     r_fault_cnt;
    logic                 r_fault;
    logic [FW-1:0]        r_frame;
    logic                 r_evict;
    logic [PAGE_W-1:0]    r_evict_page;
    logic [CW-1:0]        r_idx;
    logic                 r_pend;
    logic [FW-1:0]        r_pend_idx;
    logic [FW-1:0]        r_best;
    logic [CNT_W-1:0]     r_best_lu;
    logic [PAGE_W-1:0]    r_best_owner;

    logic                 r_out_valid;
    logic [PA_W-1:0]      r_out_pa;
    logic                 r_out_fault;
    logic [CNT_W-1:0]     r_out_total;

    logic                 in_fire;
    logic                 can_out;
    logic                 commit;
    logic [PAGE_W-1:0]    in_page;
    logic [CW-1:0]        n_active;
    logic [FW-1:0]        scan_addr;
    logic                 issue;
    logic                 free_hit;
    logic                 take;
    logic [FW+OFFSET_BITS+PA_W-1:0] pa_ext;

    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign can_out   = !r_out_valid || i_m_axis_tready;
    assign commit    = (r_state == S_WRITE) && can_out;
    assign in_page   = page_of(i_s_axis_tdata[ADDR_W-1:0]);
    assign scan_addr = r_idx[FW-1:0];

    // Clamp the frame count to 2 .. PHYSICAL_FRAMES
    always_comb begin
        if (r_frame_count < FC_MIN) begin
            n_active = CW'(FC_MIN);
        end else if (32'(r_frame_count) > PHYSICAL_FRAMES) begin
            n_active = CW'(PHYSICAL_FRAMES);
        end else begin
            n_active = CW'(r_frame_count);
        end
    end

    // Scan step: look ahead at the free mark, compare the last-use word read for the previous scan index
    always_comb begin
        issue    = (r_idx < n_active);
        free_hit = issue && r_free[scan_addr];
        take     = r_pend && ((r_pend_idx == FW'(1)) || (r_lu_rd < r_best_lu));
    end

    // Drop the evicted page first so the new page always ends up resident
    always_comb begin
        n_valid = r_valid;
        if (r_evict) begin
            n_valid[r_evict_page] = 1'b0;
        end
        n_valid[r_page] = 1'b1;
    end

    assign pa_ext = {{PA_W{1'b0}}, r_frame, r_offset};

    // Page frame table
    always_ff @(posedge i_clk) begin
        r_pf_rd <= m_page_frame[in_page];
        if (commit && r_fault) begin
            m_page_frame[r_page] <= r_frame;
        end
    end

    // Per-frame last-use time and owning page
    always_ff @(posedge i_clk) begin
        r_lu_rd  <= m_last_use[scan_addr];
        r_own_rd <= m_owner[scan_addr];
        if (commit) begin
            m_last_use[r_frame] <= r_clock;
            if (r_fault) begin
                m_owner[r_frame] <= r_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_free        <= {{(PHYSICAL_FRAMES-1){1'b1}}, 1'b0};
            r_frame_count <= FC_RESET;
            r_clock       <= '0;
            r_fault_cnt   <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_count <= i_cfg_wr_data;
            end

            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_page   <= in_page;
                        r_offset <= offset_of(i_s_axis_tdata[ADDR_W-1:0]);
                        r_clock  <= r_clock + 1'b1;
                        r_state  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (r_valid[r_page]) begin
                        r_frame <= r_pf_rd;
                        r_fault <= 1'b0;
                        r_evict <= 1'b0;
                        r_state <= S_WRITE;
                    end else begin
                        r_fault <= 1'b1;
                        if (r_fault_cnt != '1) begin
                            r_fault_cnt <= r_fault_cnt + 1'b1;
                        end
                        r_idx   <= CW'(1);
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (take) begin
                        r_best       <= r_pend_idx;
                        r_best_lu    <= r_lu_rd;
                        r_best_owner <= r_own_rd;
                    end
                    if (free_hit) begin
                        r_frame <= scan_addr;
                        r_evict <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= S_WRITE;
                    end else if (issue) begin
                        r_idx      <= r_idx + 1'b1;
                        r_pend     <= 1'b1;
                        r_pend_idx <= scan_addr;
                    end else begin
                        // Scan done with no free frame: evict the oldest
                        r_frame      <= take ? r_pend_idx : r_best;
                        r_evict_page <= take ? r_own_rd : r_best_owner;
                        r_evict      <= 1'b1;
                        r_pend       <= 1'b0;
                        r_state      <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (can_out) begin
                        if (r_fault) begin
                            r_valid         <= n_valid;
                            r_free[r_frame] <= 1'b0;
                        end
                        r_out_pa    <= pa_ext[PA_W-1:0];
                        r_out_fault <= r_fault;
                        r_out_total <= r_fault_cnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_out_total, r_out_pa};
    assign o_m_axis_tuser  = r_out_fault;

    `PTLR_ASSERT(a_frame0_reserved, !r_free[0])
    `PTLR_ASSERT(a_fault_frame_nonzero, (commit && r_fault) |-> (r_frame != '0))
    `PTLR_ASSERT(a_fault_frame_active, (commit && r_fault) |-> (CW'(r_frame) < n_active))
    `PTLR_ASSERT_NEXT(a_fault_sets_valid, (commit && r_fault), r_valid[$past(r_page)])

endmodule
